// ===== design/brld_pkg.sv =====
// shared types and constants for the byterun1 line decoder
// no dependencies
`default_nettype none

package brld_pkg;

    localparam int unsigned CODE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0] LINE_LENGTH_RST = 16'd320;
    localparam logic [LEN_W-1:0] LINE_COUNT_RST  = 16'd200;
    localparam logic [LEN_W-1:0] LINE_LENGTH_MIN = 16'd4;

    localparam logic [CODE_W-1:0] HDR_NOP  = 8'h80;
    localparam logic [CODE_W:0]   FILL_BASE = 9'h101;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_FILL    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FILL  = 2'd1,
        ST_TRUNC = 2'd2
    } t_state;

    typedef struct packed {
        logic accept;
        logic hdr;
        logic lit_step;
        logic load_fill;
        logic fill_step;
        logic emit_trunc;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic   out_free;
        logic   finished;
        t_phase phase;
        logic   lit_fin;
        logic   fill_fin;
        logic   fill_done;
        logic   eod;
    } t_status;

endpackage

`default_nettype wire

// ===== design/brld_dp.sv =====
// datapath: line geometry, run state, segment split and output register
// depends on brld_pkg
`default_nettype none

module brld_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [brld_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [brld_pkg::LEN_W-1:0]          i_cfg_data,
    input  wire logic [brld_pkg::CODE_W-1:0]         i_code,
    input  wire logic                                i_eod,
    input  wire brld_pkg::t_cmd                      i_cmd,
    output brld_pkg::t_status                        o_status,
    input  wire logic                                i_m_ready,
    output logic                                     o_m_valid,
    output logic [brld_pkg::CODE_W-1:0]              o_pixel,
    output logic [brld_pkg::CNT_W-1:0]               o_repeat,
    output logic                                     o_line_end,
    output logic                                     o_image_end,
    output logic                                     o_truncated,
    output logic                                     o_last
);

    logic [brld_pkg::LEN_W-1:0]  r_line_length, n_line_length;
    logic [brld_pkg::LEN_W-1:0]  r_line_count, n_line_count;
    brld_pkg::t_phase            r_phase, n_phase;
    logic [brld_pkg::CNT_W-1:0]  r_literal_left, n_literal_left;
    logic [brld_pkg::CNT_W-1:0]  r_fill_length, n_fill_length;
    logic [brld_pkg::LEN_W-1:0]  r_column, n_column;
    logic [brld_pkg::LEN_W-1:0]  r_line_index, n_line_index;
    logic                        r_finished, n_finished;
    logic [brld_pkg::CODE_W-1:0] r_fill_val, n_fill_val;
    logic [brld_pkg::CNT_W-1:0]  r_rem, n_rem;
    logic                        r_eod, n_eod;

    logic                        r_out_valid, n_out_valid;
    logic [brld_pkg::CODE_W-1:0] r_out_pixel, n_out_pixel;
    logic [brld_pkg::CNT_W-1:0]  r_out_repeat, n_out_repeat;
    logic                        r_out_le, n_out_le;
    logic                        r_out_ie, n_out_ie;
    logic                        r_out_tr, n_out_tr;
    logic                        r_out_last, n_out_last;

    logic [brld_pkg::LEN_W-1:0]  len;
    logic [brld_pkg::LEN_W-1:0]  lc;
    logic [brld_pkg::LEN_W-1:0]  room;
    logic [brld_pkg::CNT_W-1:0]  take;
    logic [brld_pkg::LEN_W-1:0]  li_next;
    logic                        img_hit;
    logic                        le_lit;
    logic                        le_fill;
    logic                        seg_le;
    logic [brld_pkg::CNT_W-1:0]  seg_cnt;
    logic                        out_free;

    // line geometry and segment split
    always_comb begin
        len     = (r_line_length < brld_pkg::LINE_LENGTH_MIN) ?
                  brld_pkg::LINE_LENGTH_MIN : r_line_length;
        lc      = (r_line_count == '0) ? brld_pkg::LEN_W'(1) : r_line_count;
        room    = (r_column < len) ? (len - r_column) : brld_pkg::LEN_W'(1);
        take    = ({{(brld_pkg::LEN_W-brld_pkg::CNT_W){1'b0}}, r_rem} < room) ?
                  r_rem : room[brld_pkg::CNT_W-1:0];
        li_next = r_line_index + brld_pkg::LEN_W'(1);
        img_hit = (li_next >= lc) || (li_next == '0);
        le_lit  = (room == brld_pkg::LEN_W'(1));
        le_fill = ({{(brld_pkg::LEN_W-brld_pkg::CNT_W){1'b0}}, take} >= room);
        seg_le  = i_cmd.lit_step ? le_lit : le_fill;
        seg_cnt = i_cmd.lit_step ? brld_pkg::CNT_W'(1) : take;
        out_free = !r_out_valid || i_m_ready;
    end

    always_comb begin
        o_status.out_free  = out_free;
        o_status.finished  = r_finished;
        o_status.phase     = r_phase;
        o_status.lit_fin   = le_lit && img_hit;
        o_status.fill_fin  = le_fill && img_hit;
        o_status.fill_done = (take == r_rem) || (le_fill && img_hit);
        o_status.eod       = r_eod;
    end

    always_comb begin
        n_line_length  = r_line_length;
        n_line_count   = r_line_count;
        n_phase        = r_phase;
        n_literal_left = r_literal_left;
        n_fill_length  = r_fill_length;
        n_column       = r_column;
        n_line_index   = r_line_index;
        n_finished     = r_finished;
        n_fill_val     = r_fill_val;
        n_rem          = r_rem;
        n_eod          = r_eod;
        n_out_valid    = r_out_valid;
        n_out_pixel    = r_out_pixel;
        n_out_repeat   = r_out_repeat;
        n_out_le       = r_out_le;
        n_out_ie       = r_out_ie;
        n_out_tr       = r_out_tr;
        n_out_last     = r_out_last;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                brld_pkg::REG_LINE_LENGTH: n_line_length = i_cfg_data;
                brld_pkg::REG_LINE_COUNT:  n_line_count  = i_cfg_data;
                default: ;
            endcase
        end

        if (i_m_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.accept) begin
            n_eod = i_eod;
        end

        // header byte
        if (i_cmd.hdr) begin
            if (i_code < brld_pkg::HDR_NOP) begin
                n_literal_left = i_code + brld_pkg::CNT_W'(1);
                n_phase        = brld_pkg::PH_LITERAL;
            end else if (i_code > brld_pkg::HDR_NOP) begin
                n_fill_length  = brld_pkg::CNT_W'(brld_pkg::FILL_BASE - {1'b0, i_code});
                n_phase        = brld_pkg::PH_FILL;
            end else begin
                n_phase        = brld_pkg::PH_HEADER;
            end
        end

        if (i_cmd.load_fill) begin
            n_rem         = r_fill_length;
            n_fill_val    = i_code;
            n_fill_length = '0;
            n_phase       = brld_pkg::PH_HEADER;
        end

        if (i_cmd.lit_step) begin
            n_literal_left = r_literal_left - brld_pkg::CNT_W'(1);
            if (n_literal_left == '0) begin
                n_phase = brld_pkg::PH_HEADER;
            end
        end

        if (i_cmd.fill_step) begin
            n_rem = r_rem - take;
        end

        // one segment into the output register
        if (i_cmd.lit_step || i_cmd.fill_step) begin
            if (seg_le) begin
                n_column     = '0;
                n_line_index = li_next;
                if (img_hit) begin
                    n_finished = 1'b1;
                end
            end else begin
                n_column = r_column + {{(brld_pkg::LEN_W-brld_pkg::CNT_W){1'b0}}, seg_cnt};
            end
            n_out_valid  = 1'b1;
            n_out_pixel  = i_cmd.lit_step ? i_code : r_fill_val;
            n_out_repeat = seg_cnt;
            n_out_le     = seg_le;
            n_out_ie     = seg_le && img_hit;
            n_out_tr     = 1'b0;
            n_out_last   = i_cmd.last;
        end

        if (i_cmd.emit_trunc) begin
            n_finished   = 1'b1;
            n_out_valid  = 1'b1;
            n_out_pixel  = '0;
            n_out_repeat = '0;
            n_out_le     = 1'b0;
            n_out_ie     = 1'b0;
            n_out_tr     = 1'b1;
            n_out_last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length  <= brld_pkg::LINE_LENGTH_RST;
            r_line_count   <= brld_pkg::LINE_COUNT_RST;
            r_phase        <= brld_pkg::PH_HEADER;
            r_literal_left <= '0;
            r_fill_length  <= '0;
            r_column       <= '0;
            r_line_index   <= '0;
            r_finished     <= 1'b0;
            r_rem          <= '0;
            r_eod          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_line_length  <= n_line_length;
            r_line_count   <= n_line_count;
            r_phase        <= n_phase;
            r_literal_left <= n_literal_left;
            r_fill_length  <= n_fill_length;
            r_column       <= n_column;
            r_line_index   <= n_line_index;
            r_finished     <= n_finished;
            r_rem          <= n_rem;
            r_eod          <= n_eod;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_val   <= n_fill_val;
        r_out_pixel  <= n_out_pixel;
        r_out_repeat <= n_out_repeat;
        r_out_le     <= n_out_le;
        r_out_ie     <= n_out_ie;
        r_out_tr     <= n_out_tr;
        r_out_last   <= n_out_last;
    end

    assign o_m_valid   = r_out_valid;
    assign o_pixel     = r_out_pixel;
    assign o_repeat    = r_out_repeat;
    assign o_line_end  = r_out_le;
    assign o_image_end = r_out_ie;
    assign o_truncated = r_out_tr;
    assign o_last      = r_out_last;

    a_trunc_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_tr |-> r_out_last && !r_out_le && r_out_repeat == '0)
        else $error("truncated word not last or not empty");

    a_image_end_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ie |-> r_out_le && r_out_last)
        else $error("image end without line end or last");

    a_segment_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_tr |-> r_out_repeat != '0)
        else $error("segment with zero repeat");

    a_finished_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped");

endmodule

`default_nettype wire

// ===== design/brld_ctrl.sv =====
// controller: sequences header, literal, fill split and truncation words
// depends on brld_pkg
`default_nettype none

module brld_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_valid,
    input  wire logic               i_s_eod,
    output logic                    o_s_ready,
    input  wire brld_pkg::t_status  i_status,
    output brld_pkg::t_cmd          o_cmd
);

    brld_pkg::t_state r_state, n_state;
    logic             acc;

    assign acc = i_s_valid && i_status.out_free && (r_state == brld_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brld_pkg::ST_IDLE: begin
                if (acc && !i_status.finished) begin
                    unique case (i_status.phase)
                        brld_pkg::PH_LITERAL: begin
                            if (i_s_eod && !i_status.lit_fin) begin
                                n_state = brld_pkg::ST_TRUNC;
                            end
                        end
                        brld_pkg::PH_FILL: n_state = brld_pkg::ST_FILL;
                        default: ;
                    endcase
                end
            end
            brld_pkg::ST_FILL: begin
                if (i_status.out_free && i_status.fill_done) begin
                    n_state = (i_status.eod && !i_status.fill_fin) ?
                              brld_pkg::ST_TRUNC : brld_pkg::ST_IDLE;
                end
            end
            brld_pkg::ST_TRUNC: begin
                if (i_status.out_free) begin
                    n_state = brld_pkg::ST_IDLE;
                end
            end
            default: n_state = brld_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            brld_pkg::ST_IDLE: begin
                o_s_ready    = i_status.out_free;
                o_cmd.accept = acc;
                if (acc && !i_status.finished) begin
                    unique case (i_status.phase)
                        brld_pkg::PH_LITERAL: begin
                            o_cmd.lit_step = 1'b1;
                            o_cmd.last     = !(i_s_eod && !i_status.lit_fin);
                        end
                        brld_pkg::PH_FILL: begin
                            o_cmd.load_fill = 1'b1;
                        end
                        default: begin
                            o_cmd.hdr        = 1'b1;
                            o_cmd.emit_trunc = i_s_eod;
                            o_cmd.last       = i_s_eod;
                        end
                    endcase
                end
            end
            brld_pkg::ST_FILL: begin
                if (i_status.out_free) begin
                    o_cmd.fill_step = 1'b1;
                    o_cmd.last      = i_status.fill_done &&
                                      !(i_status.eod && !i_status.fill_fin);
                end
            end
            brld_pkg::ST_TRUNC: begin
                if (i_status.out_free) begin
                    o_cmd.emit_trunc = 1'b1;
                    o_cmd.last       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brld_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != brld_pkg::ST_IDLE |-> !o_s_ready)
        else $error("input ready while busy");

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.lit_step, o_cmd.fill_step, o_cmd.emit_trunc}) <= 1)
        else $error("two words loaded in one cycle");

    a_fill_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_fill |=> r_state == brld_pkg::ST_FILL)
        else $error("fill byte did not start split");

endmodule

`default_nettype wire

// ===== design/byterun1_line_decoder.sv =====
// top level of the byterun1 (packbits) line decoder
// depends on brld_pkg, brld_ctrl, brld_dp
//
// channel   dir  tdata                        tuser                     tlast
// s_axis    in   [7:0] code_byte              -                         end_of_data
// m_axis    out  [7:0] pixel_value,           [0] line_end,             last_segment
//                [15:8] repeat_res            [1] image_end, [2] truncated
// cfg       in   index 0 line_length, index 1 line_count, 16-bit data
//
// header and literal bytes are accepted straight from the idle state while the output register is free
// a fill byte is loaded first, then put out as one word per line-split segment while input is held off
// end of data on a header byte loads the truncated word into the output register in the same cycle
// end of data on a literal or fill byte before image completion adds a truncated word after the last segment
// one controller drives a single output register, a stall on m_axis holds everything
// synchronous active-low reset, no clearing pass
`default_nettype none

module byterun1_line_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [7:0]                        i_s_axis_tdata,   // code_byte
    input  wire logic                              i_s_axis_tlast,   // end_of_data
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [15:0]                            o_m_axis_tdata,   // pixel_value, repeat_res
    output logic [2:0]                             o_m_axis_tuser,   // line_end, image_end, truncated
    output logic                                   o_m_axis_tlast,   // last_segment
    input  wire logic                              i_cfg_we,
    input  wire logic [brld_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [brld_pkg::LEN_W-1:0]        i_cfg_data
);

    brld_pkg::t_cmd    cmd;
    brld_pkg::t_status status;

    logic [brld_pkg::CODE_W-1:0] pixel;
    logic [brld_pkg::CNT_W-1:0]  repeat_cnt;
    logic                        line_end;
    logic                        image_end;
    logic                        truncated;

    brld_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_eod   (i_s_axis_tlast),
        .o_s_ready (o_s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    brld_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_code      (i_s_axis_tdata),
        .i_eod       (i_s_axis_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_m_ready   (i_m_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_pixel     (pixel),
        .o_repeat    (repeat_cnt),
        .o_line_end  (line_end),
        .o_image_end (image_end),
        .o_truncated (truncated),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {repeat_cnt, pixel};
    assign o_m_axis_tuser = {truncated, image_end, line_end};

endmodule

`default_nettype wire

// ===== dv/byterun1_line_decoder_tb.sv =====
`timescale 1ns / 100ps
// testbench for byterun1_line_decoder: feeds packbits byte streams under random
// flow control and checks every decoded run segment against a built-in line model
// depends on brld_pkg and the byterun1_line_decoder rtl

module byterun1_line_decoder_tb;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 320;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 12;

    localparam logic [7:0] HDR_LIT_ONE  = 8'h00;
    localparam logic [7:0] HDR_LIT_MAX  = 8'h7F;
    localparam logic [7:0] HDR_FILL_MAX = 8'h81;
    localparam logic [7:0] HDR_FILL_MIN = 8'hFF;

    typedef struct packed {
        logic [7:0] code;
        logic       eod;
    } t_code_word;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] rep;
        logic       line_end;
        logic       image_end;
        logic       truncated;
        logic       last;
    } t_segment;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data    = '0;
    logic             s_last    = 1'b0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [15:0]      m_data;
    logic [2:0]       m_user;
    logic             m_last;
    logic             cfg_we    = 1'b0;
    logic [brld_pkg::CFG_IDX_W-1:0] cfg_index = brld_pkg::REG_LINE_LENGTH;
    logic [brld_pkg::LEN_W-1:0]     cfg_data  = '0;

    t_code_word bytes_q[$];
    t_segment   segs_due[$];

    // line decoder model
    logic [15:0]      line_len_reg = brld_pkg::LINE_LENGTH_RST;
    logic [15:0]      line_cnt_reg = brld_pkg::LINE_COUNT_RST;
    brld_pkg::t_phase dec_phase    = brld_pkg::PH_HEADER;
    logic [7:0]       lit_left     = '0;
    logic [7:0]       fill_left    = '0;
    logic [15:0]      column       = '0;
    logic [15:0]      line_idx     = '0;
    logic             done         = 1'b0;

    int errors        = 0;
    int queued        = 0;
    int words_in      = 0;
    int segs_out      = 0;
    int line_ends     = 0;
    int image_ends    = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    byterun1_line_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int unsigned room_left();
        int unsigned len;
        len = (line_len_reg < brld_pkg::LINE_LENGTH_MIN) ?
              32'(brld_pkg::LINE_LENGTH_MIN) : 32'(line_len_reg);
        return (32'(column) < len) ? len - 32'(column) : 32'd1;
    endfunction

    task automatic push_segment(input logic [7:0] val, input int unsigned cnt);
        int unsigned lines;
        t_segment    s;
        lines   = (line_cnt_reg == 16'd0) ? 32'd1 : 32'(line_cnt_reg);
        s       = '0;
        s.value = val;
        s.rep   = cnt[7:0];
        if (cnt >= room_left()) begin
            s.line_end = 1'b1;
            column     = '0;
            line_idx   = line_idx + 16'd1;
            if (32'(line_idx) >= lines || line_idx == 16'd0) begin
                done        = 1'b1;
                s.image_end = 1'b1;
            end
        end else begin
            column = column + cnt[15:0];
        end
        segs_due.push_back(s);
    endtask

    task automatic decode_word(input t_code_word w);
        int          n;
        int unsigned rem;
        int unsigned take;
        t_segment    t;
        n = segs_due.size();
        if (done) begin
            return;
        end
        case (dec_phase)
            brld_pkg::PH_LITERAL: begin
                push_segment(w.code, 1);
                lit_left = lit_left - 8'd1;
                if (lit_left == 8'd0) begin
                    dec_phase = brld_pkg::PH_HEADER;
                end
            end
            brld_pkg::PH_FILL: begin
                rem = 32'(fill_left);
                while (rem != 0 && !done) begin
                    take = room_left();
                    if (rem < take) begin
                        take = rem;
                    end
                    push_segment(w.code, take);
                    rem = rem - take;
                end
                fill_left = '0;
                dec_phase = brld_pkg::PH_HEADER;
            end
            default: begin
                dec_phase = brld_pkg::PH_HEADER;
                if (w.code < brld_pkg::HDR_NOP) begin
                    lit_left  = w.code + 8'd1;
                    dec_phase = brld_pkg::PH_LITERAL;
                end else if (w.code > brld_pkg::HDR_NOP) begin
                    fill_left = 8'(brld_pkg::FILL_BASE - {1'b0, w.code});
                    dec_phase = brld_pkg::PH_FILL;
                end
            end
        endcase
        if (w.eod && !done) begin
            t           = '0;
            t.truncated = 1'b1;
            segs_due.push_back(t);
            done = 1'b1;
        end
        if (segs_due.size() > n) begin
            t      = segs_due.pop_back();
            t.last = 1'b1;
            segs_due.push_back(t);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // sender
    always @(posedge i_clk) begin : drive
        t_code_word w;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = bytes_q.pop_front();
                s_valid <= 1'b1;
                s_data  <= w.code;
                s_last  <= w.eod;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off while the sender keeps offering
    always @(posedge i_clk) begin : sink
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (!hold_done && words_in >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_code_word w;
        t_segment   e;
        t_segment   got;
        if (i_rst_n) begin
            if (cfg_we) begin
                case (cfg_index)
                    brld_pkg::REG_LINE_LENGTH: line_len_reg = cfg_data;
                    brld_pkg::REG_LINE_COUNT:  line_cnt_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                w.code = s_data;
                w.eod  = s_last;
                decode_word(w);
                words_in <= words_in + 1;
            end
            if (m_valid && m_ready) begin
                got.value     = m_data[7:0];
                got.rep       = m_data[15:8];
                got.line_end  = m_user[0];
                got.image_end = m_user[1];
                got.truncated = m_user[2];
                got.last      = m_last;
                segs_out++;
                if (segs_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none actual value %0d rep %0d",
                             $time, got.value, got.rep);
                end else begin
                    e = segs_due.pop_front();
                    check_field("pixel_value", e.value, got.value);
                    check_field("repeat_res", e.rep, got.rep);
                    check_field("line_end", 8'(e.line_end), 8'(got.line_end));
                    check_field("image_end", 8'(e.image_end), 8'(got.image_end));
                    check_field("truncated", 8'(e.truncated), 8'(got.truncated));
                    check_field("last_segment", 8'(e.last), 8'(got.last));
                    line_ends  += int'(e.line_end);
                    image_ends += int'(e.image_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("byterun1_line_decoder: mismatch");
            $finish;
        end
    end

    task automatic push_code(input logic [7:0] b, input logic eod = 1'b0);
        t_code_word w;
        w.code = b;
        w.eod  = eod;
        bytes_q.push_back(w);
        queued++;
    endtask

    task automatic set_geometry(input logic [15:0] len, input logic [15:0] cnt);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= brld_pkg::REG_LINE_LENGTH;
        cfg_data  <= len;
        @(posedge i_clk);
        cfg_index <= brld_pkg::REG_LINE_COUNT;
        cfg_data  <= cnt;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        while (bytes_q.size() != 0 || s_valid || segs_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one packbits packet, mostly well formed, some noise and short literals
    task automatic add_packet();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 6) begin
            push_code(8'($urandom_range(255)));
        end else if (kind < 12) begin
            push_code(brld_pkg::HDR_NOP);
        end else if (kind < 15) begin
            n = $urandom_range(127, 16);
            push_code(n[7:0]);
            repeat (n + 1) push_code(8'($urandom_range(255)));
        end else if (kind < 55) begin
            n = $urandom_range(7, 0);
            push_code(n[7:0]);
            repeat (n + 1) push_code(8'($urandom_range(255)));
        end else if (kind < 59) begin
            n = $urandom_range(7, 2);
            push_code(n[7:0]);
            repeat (n / 2) push_code(8'($urandom_range(255)));
        end else begin
            push_code(8'($urandom_range(255, 129)));
            push_code(8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short line length, every header kind and the byte extremes
        set_geometry(16'd0, 16'hFFFF);
        push_code(brld_pkg::HDR_NOP);
        push_code(HDR_LIT_ONE);
        push_code(8'hFF);
        push_code(8'h03);
        push_code(8'h00);
        push_code(8'hFF);
        push_code(8'h55);
        push_code(8'hAA);
        push_code(HDR_FILL_MIN);
        push_code(8'h00);
        push_code(HDR_FILL_MAX);
        push_code(8'hFF);
        push_code(8'h01);
        push_code(brld_pkg::HDR_NOP);
        push_code(HDR_LIT_MAX);
        push_code(brld_pkg::HDR_NOP);
        push_code(8'hFE);
        push_code(8'h5A);
        wait_idle();

        send_idle_pct = 20;
        recv_idle_pct = 62;
        set_geometry(16'hFFFF, 16'hFFFF);
        while (queued < 160) add_packet();
        wait_idle();

        // shorter lines while the column is deep into a long one
        send_idle_pct = 62;
        recv_idle_pct = 20;
        set_geometry(16'($urandom_range(40, 4)), 16'($urandom_range(65534, 30000)));
        while (queued < 290) add_packet();
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_geometry(brld_pkg::LINE_LENGTH_MIN, 16'hFFFF);
        while (queued < 405) add_packet();
        wait_idle();

        // get back to a header boundary
        if (dec_phase == brld_pkg::PH_LITERAL) begin
            repeat (lit_left) push_code(8'($urandom_range(255)));
        end else if (dec_phase == brld_pkg::PH_FILL) begin
            push_code(8'($urandom_range(255)));
        end
        wait_idle();

        // zero line count: next line end completes the image, rest is dropped
        set_geometry(16'd3, 16'd0);
        push_code(HDR_FILL_MAX);
        push_code(8'hA5);
        push_code(8'h05);
        push_code(8'h12);
        push_code(8'h34, 1'b1);
        wait_idle();

        $display("decoded %0d code words into %0d segments, %0d line ends, %0d image end",
                 words_in, segs_out, line_ends, image_ends);
        $display("covered literal, fill and no-op runs, line splits, a long output stall");
        if (errors == 0 && segs_due.size() == 0) begin
            $display("byterun1_line_decoder: match");
        end else begin
            $display("byterun1_line_decoder: mismatch");
        end
        $finish;
    end

endmodule
